[sv/frt_pkg.sv]
// ---------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ---------------------------------------------------------------------------
package frt_pkg;

  // Table geometry.
  localparam int SLOT_COUNT     = 8;
  localparam int SLOT_W         = 3;
  localparam int MAX_FRAGMENTS  = 16;
  localparam int FRAG_W         = 4;
  localparam int FRAGMENT_BYTES = 1024;
  localparam int FB_SHIFT       = 10;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SILENCE_MASK = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
  localparam logic [1:0] CFG_MAX_BYTES    = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_TIME_BACK    = 4'd1;
  localparam logic [3:0] ERR_MALFORMED    = 4'd2;
  localparam logic [3:0] ERR_NOT_AUDIO    = 4'd3;
  localparam logic [3:0] ERR_ZERO_FRAME   = 4'd4;
  localparam logic [3:0] ERR_TOO_MANY     = 4'd5;
  localparam logic [3:0] ERR_SILENCE_PAY  = 4'd6;
  localparam logic [3:0] ERR_NONCANONICAL = 4'd7;
  localparam logic [3:0] ERR_EMPTY        = 4'd8;
  localparam logic [3:0] ERR_TOO_LARGE    = 4'd9;
  localparam logic [3:0] ERR_TABLE_FULL   = 4'd10;
  localparam logic [3:0] ERR_INCONSISTENT = 4'd11;
  localparam logic [3:0] ERR_DUPLICATE    = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EXPIRE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic set_back;
    logic time_upd;
    logic expire_step;
    logic scan_step;
    logic commit;
  } frt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic time_back;
    logic idx_last;
    logic finish_early;
  } frt_stat_t;

endpackage

[sv/frt_ctrl.sv]
// ---------------------------------------------------------------------------
// frt_ctrl
// Controller that sequences the time check, expiry sweep, slot search and
// commit for one item.
// ---------------------------------------------------------------------------
module frt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  frt_pkg::frt_stat_t stat,
  output frt_pkg::frt_cmd_t  cmd,
  output logic              busy,
  output logic              result_valid
);
  import frt_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.time_back) begin
          cmd.set_back = 1'b1;
          state_next = ST_RESULT;
        end else begin
          cmd.time_upd = 1'b1;
          state_next = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        cmd.expire_step = 1'b1;
        if (stat.idx_last) begin
          state_next = stat.finish_early ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign result_valid = (state == ST_RESULT);

endmodule

[sv/frt_dpath.sv]
// ---------------------------------------------------------------------------
// frt_dpath
// Datapath: configuration registers, slot table, shape checks and the
// result registers.
// ---------------------------------------------------------------------------
module frt_dpath (
  input  logic               clk,
  input  logic               rst,
  input  frt_pkg::frt_cmd_t  cmd,
  output frt_pkg::frt_stat_t stat,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               func,
  input  logic [47:0]        now_ms,
  input  logic               parse_ok,
  input  logic               is_audio,
  input  logic [31:0]        strm_id,
  input  logic [31:0]        frm_id,
  input  logic [31:0]        seq_num,
  input  logic [31:0]        sample_stamp,
  input  logic [15:0]        flags,
  input  logic [7:0]         frag_pos,
  input  logic [7:0]         frag_cnt,
  input  logic [15:0]        payload_bytes,
  output logic [3:0]         error_code,
  output logic [3:0]         expired_count,
  output logic               frame_done,
  output logic [2:0]         slot_index,
  output logic [13:0]        write_offset,
  output logic [31:0]        done_strm_id,
  output logic [31:0]        done_first_sequence,
  output logic [31:0]        done_timestamp,
  output logic [31:0]        done_frame_id,
  output logic [15:0]        done_flags,
  output logic [14:0]        frame_bytes,
  output logic [3:0]         in_flight_count
);
  import frt_pkg::*;

  // Configuration registers.
  logic [15:0] silence_mask;
  logic [31:0] timeout_ms;
  logic [14:0] max_bytes;

  // Latched item.
  logic        f_func, f_parse, f_audio;
  logic [47:0] f_now;
  logic [31:0] f_stream, f_frame, f_seq, f_stamp;
  logic [15:0] f_flags, f_pay;
  logic [7:0]  f_idx, f_cnt;

  // Slot table.
  logic [SLOT_COUNT-1:0] slot_active;
  logic [31:0] slot_stream   [SLOT_COUNT];
  logic [31:0] slot_frame    [SLOT_COUNT];
  logic [31:0] slot_first_seq[SLOT_COUNT];
  logic [31:0] slot_stamp    [SLOT_COUNT];
  logic [15:0] slot_flag_bits[SLOT_COUNT];
  logic [7:0]  slot_frag_total[SLOT_COUNT];
  logic [47:0] slot_last_arr [SLOT_COUNT];
  logic [MAX_FRAGMENTS-1:0] slot_map[SLOT_COUNT];
  logic [4:0]  slot_rtotal   [SLOT_COUNT];
  logic [10:0] slot_final    [SLOT_COUNT];

  logic        time_seen;
  logic [47:0] last_time;

  // Sweep state and result registers.
  logic [SLOT_W-1:0] idx;
  logic              hit_found, free_found;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic [3:0]        err, expired;
  logic              acc_ok, done_ok;
  logic [SLOT_W-1:0] sel_reg;
  logic [14:0]       bytes_reg;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_mask <= 16'd0;
      timeout_ms   <= 32'd1000;
      max_bytes    <= 15'd16384;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SILENCE_MASK: silence_mask <= cfg_data[15:0];
        CFG_TIMEOUT:      timeout_ms <= cfg_data;
        CFG_MAX_BYTES:    max_bytes <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Shape checks of the latched fragment, in priority order.
  logic [3:0]  frag_err;
  logic        silent, is_final;
  logic [23:0] end_off;
  always_comb begin
    silent   = (f_flags & silence_mask) != 16'd0;
    is_final = ({1'b0, f_idx} + 9'd1) == {1'b0, f_cnt};
    end_off  = (24'(f_idx) << FB_SHIFT) + 24'(f_pay);
    if (f_func) frag_err = ERR_NONE;
    else if (!f_parse) frag_err = ERR_MALFORMED;
    else if (!f_audio) frag_err = ERR_NOT_AUDIO;
    else if (f_frame == 32'd0) frag_err = ERR_ZERO_FRAME;
    else if (f_cnt > 8'(MAX_FRAGMENTS)) frag_err = ERR_TOO_MANY;
    else if (f_cnt == 8'd0 || f_idx >= f_cnt) frag_err = ERR_NONCANONICAL;
    else if (silent) begin
      if (f_pay != 16'd0) frag_err = ERR_SILENCE_PAY;
      else if (f_cnt != 8'd1 || f_idx != 8'd0) frag_err = ERR_NONCANONICAL;
      else frag_err = ERR_NONE;
    end
    else if (f_pay == 16'd0) frag_err = ERR_EMPTY;
    else if (!is_final && f_pay != 16'(FRAGMENT_BYTES)) frag_err = ERR_NONCANONICAL;
    else if (f_pay > 16'(FRAGMENT_BYTES)) frag_err = ERR_NONCANONICAL;
    else if (end_off > 24'(max_bytes)) frag_err = ERR_TOO_LARGE;
    else frag_err = ERR_NONE;
  end

  // Per-slot tests at the sweep index.
  logic [47:0] age;
  logic        timed_out, key_match;
  assign age       = f_now - slot_last_arr[idx];
  assign timed_out = slot_active[idx] && (age >= {16'd0, timeout_ms});
  assign key_match = slot_active[idx] && slot_stream[idx] == f_stream &&
                     slot_frame[idx] == f_frame;

  // Commit decision for the chosen slot.
  logic [SLOT_W-1:0]        sel;
  logic [FRAG_W-1:0]        fidx;
  logic [31:0]              first_seq;
  logic                     mismatch, dup;
  logic [MAX_FRAGMENTS-1:0] map_new;
  logic [4:0]               rtot_new;
  logic [10:0]              final_new;
  logic                     completes;
  always_comb begin
    sel       = hit_found ? hit_idx : free_idx;
    fidx      = f_idx[FRAG_W-1:0];
    first_seq = f_seq - 32'(f_idx);
    mismatch  = slot_first_seq[sel] != first_seq || slot_stamp[sel] != f_stamp ||
                slot_flag_bits[sel] != f_flags || slot_frag_total[sel] != f_cnt;
    dup       = hit_found && slot_map[sel][fidx];
    map_new   = (hit_found ? slot_map[sel] : '0) | (MAX_FRAGMENTS'(1) << fidx);
    rtot_new  = (hit_found ? slot_rtotal[sel] : 5'd0) + 5'd1;
    final_new = is_final ? f_pay[10:0] : (hit_found ? slot_final[sel] : 11'd0);
    completes = {3'd0, rtot_new} == f_cnt;
  end

  // Control registers: time, sweep, status of the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      time_seen   <= 1'b0;
      last_time   <= 48'd0;
      idx         <= '0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
      err         <= ERR_NONE;
      expired     <= 4'd0;
      acc_ok      <= 1'b0;
      done_ok     <= 1'b0;
    end else begin
      if (cmd.load) begin
        err     <= ERR_NONE;
        expired <= 4'd0;
        acc_ok  <= 1'b0;
        done_ok <= 1'b0;
      end
      if (cmd.set_back) begin
        err <= ERR_TIME_BACK;
      end
      if (cmd.time_upd) begin
        time_seen <= 1'b1;
        last_time <= f_now;
        idx       <= '0;
      end
      // Expiry sweep: one slot a cycle.
      if (cmd.expire_step) begin
        if (timed_out) begin
          slot_active[idx] <= 1'b0;
          expired <= expired + 4'd1;
        end
        if (stat.idx_last) begin
          idx        <= '0;
          err        <= frag_err;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
        end else begin
          idx <= idx + SLOT_W'(1);
        end
      end
      // Slot search: first matching slot, else first free slot.
      if (cmd.scan_step) begin
        if (!hit_found && key_match) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (!free_found && !slot_active[idx]) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        idx <= stat.idx_last ? '0 : idx + SLOT_W'(1);
      end
      if (cmd.commit) begin
        if (!hit_found && !free_found) err <= ERR_TABLE_FULL;
        else if (hit_found && mismatch) err <= ERR_INCONSISTENT;
        else if (dup) err <= ERR_DUPLICATE;
        else begin
          acc_ok  <= 1'b1;
          done_ok <= completes;
          slot_active[sel] <= !completes;
        end
      end
    end
  end

  // Slot payload and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_func   <= func;
      f_now    <= now_ms;
      f_parse  <= parse_ok;
      f_audio  <= is_audio;
      f_stream <= strm_id;
      f_frame  <= frm_id;
      f_seq    <= seq_num;
      f_stamp  <= sample_stamp;
      f_flags  <= flags;
      f_idx    <= frag_pos;
      f_cnt    <= frag_cnt;
      f_pay    <= payload_bytes;
    end
    if (cmd.commit) begin
      sel_reg   <= sel;
      bytes_reg <= 15'(((f_cnt - 8'd1) << FB_SHIFT)) + 15'(final_new);
      if ((hit_found || free_found) && !(hit_found && mismatch) && !dup) begin
        slot_stream[sel]     <= f_stream;
        slot_frame[sel]      <= f_frame;
        slot_first_seq[sel]  <= first_seq;
        slot_stamp[sel]      <= f_stamp;
        slot_flag_bits[sel]  <= f_flags;
        slot_frag_total[sel] <= f_cnt;
        slot_last_arr[sel]   <= f_now;
        slot_map[sel]        <= map_new;
        slot_rtotal[sel]     <= rtot_new;
        slot_final[sel]      <= final_new;
      end
    end
  end

  // Status to the controller.
  assign stat.time_back    = time_seen && (f_now < last_time);
  assign stat.idx_last     = (idx == SLOT_W'(SLOT_COUNT - 1));
  assign stat.finish_early = f_func || (frag_err != ERR_NONE);

  // Result fields; matched slot fields equal the latched header here.
  assign error_code          = err;
  assign expired_count       = expired;
  assign frame_done          = done_ok;
  assign slot_index          = acc_ok ? sel_reg : 3'd0;
  assign write_offset        = acc_ok ? (14'(f_idx[FRAG_W-1:0]) << FB_SHIFT) : 14'd0;
  assign done_strm_id        = done_ok ? f_stream : 32'd0;
  assign done_first_sequence = done_ok ? (f_seq - 32'(f_idx)) : 32'd0;
  assign done_timestamp      = done_ok ? f_stamp : 32'd0;
  assign done_frame_id       = done_ok ? f_frame : 32'd0;
  assign done_flags          = done_ok ? f_flags : 16'd0;
  assign frame_bytes         = done_ok ? bytes_reg : 15'd0;
  assign in_flight_count     = 4'($countones(slot_active));

endmodule

[sv/fragment_reassembly_tracker.sv]
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks frames under reassembly in a table of slots, expires idle slots and
// reports completed frames.
// ---------------------------------------------------------------------------
//  Channel   Signals                               Direction
//  item      start, busy, func .. payload_bytes    in
//  result    result_valid, error_code .. count     out
//  config    cfg_write, cfg_index, cfg_data        in
//
// An item that reaches the commit step shows its result after a time check,
// an expiry sweep and a slot search over all eight slots, each one slot a
// cycle, then the commit step and the result state. A time tick or a
// rejected header goes from the sweep straight to the result state; time
// running backwards goes there straight from the time check. busy drops
// after the result state, and the next item is taken once it is idle again.
// The result shows for one cycle with result_valid; the receiver
// cannot stall it. rst is synchronous and clears the table and the time.
module fragment_reassembly_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        result_valid,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        func,
  input  logic [47:0] now_ms,
  input  logic        parse_ok,
  input  logic        is_audio,
  input  logic [31:0] strm_id,
  input  logic [31:0] frm_id,
  input  logic [31:0] seq_num,
  input  logic [31:0] sample_stamp,
  input  logic [15:0] flags,
  input  logic [7:0]  frag_pos,
  input  logic [7:0]  frag_cnt,
  input  logic [15:0] payload_bytes,
  output logic [3:0]  error_code,
  output logic [3:0]  expired_count,
  output logic        frame_done,
  output logic [2:0]  slot_index,
  output logic [13:0] write_offset,
  output logic [31:0] done_strm_id,
  output logic [31:0] done_first_sequence,
  output logic [31:0] done_timestamp,
  output logic [31:0] done_frame_id,
  output logic [15:0] done_flags,
  output logic [14:0] frame_bytes,
  output logic [3:0]  in_flight_count
);
  import frt_pkg::*;

  frt_cmd_t  cmd;
  frt_stat_t stat;

  // Sequencer.
  frt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // Table and checks.
  frt_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .func                (func),
    .now_ms              (now_ms),
    .parse_ok            (parse_ok),
    .is_audio            (is_audio),
    .strm_id             (strm_id),
    .frm_id              (frm_id),
    .seq_num             (seq_num),
    .sample_stamp        (sample_stamp),
    .flags               (flags),
    .frag_pos            (frag_pos),
    .frag_cnt            (frag_cnt),
    .payload_bytes       (payload_bytes),
    .error_code          (error_code),
    .expired_count       (expired_count),
    .frame_done          (frame_done),
    .slot_index          (slot_index),
    .write_offset        (write_offset),
    .done_strm_id        (done_strm_id),
    .done_first_sequence (done_first_sequence),
    .done_timestamp      (done_timestamp),
    .done_frame_id       (done_frame_id),
    .done_flags          (done_flags),
    .frame_bytes         (frame_bytes),
    .in_flight_count     (in_flight_count)
  );

  // A result is shown for one cycle and then the block goes idle.
  a_result_one_cycle: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !busy)
    else $error("result held longer than one cycle");

  // An accepted item makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted without going busy");

  // A completed frame carries no error.
  a_done_no_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_done |-> error_code == ERR_NONE)
    else $error("frame completed with an error code");

  // Time running backwards expires nothing.
  a_back_no_expire: assert property (@(posedge clk) disable iff (rst)
    result_valid && error_code == ERR_TIME_BACK |-> expired_count == 4'd0)
    else $error("slots expired on backwards time");

  // The active count never exceeds the table size.
  a_inflight_range: assert property (@(posedge clk) disable iff (rst)
    in_flight_count <= 4'(SLOT_COUNT))
    else $error("active slot count out of range");

endmodule

[tb/sv/fragment_reassembly_tracker_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker_tb
// Drives fragment headers and time ticks into the reassembly tracker and
// compares every result against a behavioral model of the slot table.
// ---------------------------------------------------------------------------
module fragment_reassembly_tracker_tb;
  import frt_pkg::*;

  typedef struct {
    logic        fn;
    logic [47:0] now;
    logic        pok;
    logic        aud;
    logic [31:0] sid;
    logic [31:0] fid;
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [15:0] flg;
    logic [7:0]  idx;
    logic [7:0]  cnt;
    logic [15:0] pay;
    // Non-item entries: a config write or a drain pause.
    logic        is_cfg;
    logic        is_drain;
    logic [1:0]  reg_sel;
    logic [31:0] reg_val;
  } frag_item_t;

  typedef struct {
    logic [3:0]  err;
    logic [3:0]  expired;
    logic        done;
    logic [2:0]  slot;
    logic [13:0] offset;
    logic [31:0] d_sid;
    logic [31:0] d_seq;
    logic [31:0] d_stamp;
    logic [31:0] d_fid;
    logic [15:0] d_flg;
    logic [14:0] bytes;
    logic [3:0]  inflight;
  } frag_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, result_valid;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic func = 1'b0;
  logic [47:0] now_ms = '0;
  logic parse_ok = 1'b0, is_audio = 1'b0;
  logic [31:0] strm_id = '0, frm_id = '0, seq_num = '0;
  logic [31:0] sample_stamp = '0;
  logic [15:0] flags = '0;
  logic [7:0] frag_pos = '0, frag_cnt = '0;
  logic [15:0] payload_bytes = '0;
  logic [3:0] error_code, expired_count, in_flight_count;
  logic frame_done;
  logic [2:0] slot_index;
  logic [13:0] write_offset;
  logic [31:0] done_strm_id, done_first_sequence, done_timestamp, done_frame_id;
  logic [15:0] done_flags;
  logic [14:0] frame_bytes;

  fragment_reassembly_tracker DUT (.*);

  initial forever #10 clk = ~clk;

  // Model state of the slot table.
  logic [15:0] m_silence;
  logic [31:0] m_timeout;
  logic [14:0] m_max_bytes;
  logic        t_active [SLOT_COUNT];
  logic [31:0] t_sid [SLOT_COUNT];
  logic [31:0] t_fid [SLOT_COUNT];
  logic [31:0] t_seq [SLOT_COUNT];
  logic [31:0] t_stamp [SLOT_COUNT];
  logic [15:0] t_flg [SLOT_COUNT];
  logic [7:0]  t_total [SLOT_COUNT];
  logic [47:0] t_last [SLOT_COUNT];
  logic [15:0] t_map [SLOT_COUNT];
  logic [4:0]  t_got [SLOT_COUNT];
  logic [15:0] t_final [SLOT_COUNT];
  logic        m_time_seen;
  logic [47:0] m_last_time;

  frag_item_t   pending_items[$];
  frag_result_t expected_results[$];
  int fail_count = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  task automatic clear_table();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      t_active[s] = 0; t_sid[s] = 0; t_fid[s] = 0; t_seq[s] = 0; t_stamp[s] = 0;
      t_flg[s] = 0; t_total[s] = 0; t_last[s] = 0; t_map[s] = 0; t_got[s] = 0;
      t_final[s] = 0;
    end
  endtask

  function automatic logic [3:0] count_active();
    logic [3:0] n;
    n = 0;
    for (int s = 0; s < SLOT_COUNT; s++) n += t_active[s];
    return n;
  endfunction

  function automatic logic [3:0] shape_error(frag_item_t it);
    int idx, cnt, pay;
    idx = it.idx; cnt = it.cnt; pay = it.pay;
    if (cnt > MAX_FRAGMENTS) return ERR_TOO_MANY;
    if (cnt == 0 || idx >= cnt) return ERR_NONCANONICAL;
    if ((it.flg & m_silence) != 0) begin
      if (pay != 0) return ERR_SILENCE_PAY;
      if (cnt != 1 || idx != 0) return ERR_NONCANONICAL;
      return ERR_NONE;
    end
    if (pay == 0) return ERR_EMPTY;
    if (idx + 1 != cnt && pay != FRAGMENT_BYTES) return ERR_NONCANONICAL;
    if (pay > FRAGMENT_BYTES) return ERR_NONCANONICAL;
    if (idx * FRAGMENT_BYTES + pay > m_max_bytes) return ERR_TOO_LARGE;
    return ERR_NONE;
  endfunction

  // Computes the result of one item and updates the model table.
  task automatic track_fragment(input frag_item_t it, output frag_result_t r);
    int hit, free_s;
    logic [31:0] first;
    logic [47:0] age;
    r = '{default: '0};
    if (m_time_seen && it.now < m_last_time) begin
      r.err = ERR_TIME_BACK;
      r.inflight = count_active();
      return;
    end
    m_time_seen = 1; m_last_time = it.now;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      age = it.now - t_last[s];
      if (t_active[s] && {16'd0, age} >= {32'd0, m_timeout}) begin
        t_active[s] = 0; t_map[s] = 0; t_got[s] = 0; t_final[s] = 0; t_last[s] = 0;
        r.expired++;
      end
    end
    if (it.fn) begin
      r.inflight = count_active();
      return;
    end
    if (!it.pok) r.err = ERR_MALFORMED;
    else if (!it.aud) r.err = ERR_NOT_AUDIO;
    else if (it.fid == 0) r.err = ERR_ZERO_FRAME;
    else r.err = shape_error(it);
    if (r.err == ERR_NONE) begin
      first = it.seq - it.idx;
      hit = -1; free_s = -1;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (hit < 0 && t_active[s] && t_sid[s] == it.sid && t_fid[s] == it.fid) hit = s;
        if (hit < 0 && !t_active[s] && free_s < 0) free_s = s;
      end
      if (hit < 0 && free_s < 0) r.err = ERR_TABLE_FULL;
      else if (hit < 0) begin
        hit = free_s;
        t_active[hit] = 1; t_sid[hit] = it.sid; t_fid[hit] = it.fid;
        t_seq[hit] = first; t_stamp[hit] = it.stamp; t_flg[hit] = it.flg;
        t_total[hit] = it.cnt; t_map[hit] = 0; t_got[hit] = 0; t_final[hit] = 0;
      end else if (t_seq[hit] != first || t_stamp[hit] != it.stamp ||
                   t_flg[hit] != it.flg || t_total[hit] != it.cnt)
        r.err = ERR_INCONSISTENT;
      if (r.err == ERR_NONE && t_map[hit][it.idx[3:0]]) r.err = ERR_DUPLICATE;
      if (r.err == ERR_NONE) begin
        t_map[hit][it.idx[3:0]] = 1;
        if (it.idx + 8'd1 == it.cnt) t_final[hit] = it.pay;
        t_got[hit]++;
        t_last[hit] = it.now;
        r.slot = hit[2:0];
        r.offset = 14'(it.idx * FRAGMENT_BYTES);
        if (t_got[hit] == t_total[hit]) begin
          r.done = 1; r.d_sid = t_sid[hit]; r.d_seq = t_seq[hit];
          r.d_stamp = t_stamp[hit]; r.d_fid = t_fid[hit]; r.d_flg = t_flg[hit];
          r.bytes = 15'((t_total[hit] - 1) * FRAGMENT_BYTES + t_final[hit]);
          t_active[hit] = 0; t_map[hit] = 0; t_got[hit] = 0; t_final[hit] = 0;
          t_last[hit] = 0;
        end
      end
    end
    r.inflight = count_active();
  endtask

  // Stimulus builders.
  logic [47:0] clock_ms = 48'd5;

  function automatic frag_item_t good_frag(logic [31:0] sid, logic [31:0] fid,
      logic [31:0] seq0, logic [31:0] stamp, logic [15:0] flg, int idx, int cnt,
      int last_pay);
    frag_item_t it;
    it = '{default: '0};
    it.pok = 1; it.aud = 1; it.sid = sid; it.fid = fid; it.seq = seq0 + idx;
    it.stamp = stamp; it.flg = flg; it.idx = 8'(idx); it.cnt = 8'(cnt);
    it.pay = 16'((idx == cnt - 1) ? last_pay : FRAGMENT_BYTES);
    it.now = clock_ms;
    return it;
  endfunction

  task automatic push(frag_item_t it);
    pending_items.push_back(it);
  endtask

  task automatic push_cfg(logic [1:0] sel, logic [31:0] val);
    frag_item_t it;
    it = '{default: '0};
    it.is_drain = 1; pending_items.push_back(it);
    it.is_drain = 0; it.is_cfg = 1; it.reg_sel = sel; it.reg_val = val;
    pending_items.push_back(it);
  endtask

  task automatic push_frame(logic [31:0] sid, logic [31:0] fid, int cnt, bit shuffle,
                            int quirk);
    int order[$];
    int j, tmp;
    logic [31:0] seq0, stamp;
    logic [15:0] flg;
    int last_pay;
    frag_item_t it;
    seq0 = $urandom; stamp = $urandom; flg = 16'($urandom & 32'h7FFF);
    last_pay = $urandom_range(1, FRAGMENT_BYTES);
    for (int i = 0; i < cnt; i++) order.push_back(i);
    if (shuffle)
      for (int i = cnt - 1; i > 0; i--) begin
        j = $urandom_range(0, i); tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
    foreach (order[k]) begin
      clock_ms += $urandom_range(0, 30);
      it = good_frag(sid, fid, seq0, stamp, flg, order[k], cnt, last_pay);
      if (quirk == 1 && k == 1) push(it);
      if (quirk == 2 && k == cnt - 1) it.stamp ^= 32'h1;
      push(it);
    end
  endtask

  // Random noise item over the header fields; its time is the current clock_ms.
  function automatic frag_item_t noise_item();
    frag_item_t it;
    it = '{default: '0};
    it.fn = ($urandom_range(0, 5) == 0);
    it.now = clock_ms;
    it.pok = ($urandom_range(0, 9) != 0); it.aud = ($urandom_range(0, 9) != 0);
    it.sid = $urandom_range(0, 3); it.fid = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) begin
      it.sid = $urandom; it.fid = $urandom;
    end
    it.seq = $urandom; it.stamp = $urandom; it.flg = 16'($urandom);
    it.idx = 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16));
    it.cnt = 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 17));
    it.pay = 16'($urandom_range(0, 2) == 0 ? $urandom : FRAGMENT_BYTES);
    return it;
  endfunction

  // Fill the item queue: directed part, then random frames and noise.
  initial begin
    frag_item_t it;
    // Directed part.
    it = good_frag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   0, 1, FRAGMENT_BYTES);
    push(it);
    it.fn = 1; it.now = 48'd3; push(it);
    it = noise_item(); it.fn = 0; it.pok = 0; push(it);
    it.pok = 1; it.aud = 0; push(it);
    it.aud = 1; it.fid = 0; push(it);
    it = good_frag(1, 1, 0, 0, 0, 0, 17, 1); it.cnt = 8'hFF; it.idx = 8'hFF; push(it);
    it.cnt = 0; it.idx = 0; push(it);
    it.cnt = 2; it.idx = 2; push(it);
    it.cnt = 2; it.idx = 1; it.pay = 0; push(it);
    it.idx = 0; it.pay = 16'hFFFF; push(it);
    it.idx = 1; it.pay = FRAGMENT_BYTES + 1; push(it);
    push_frame(7, 9, 16, 0, 0);
    push_frame(7, 10, 3, 1, 1);
    push_frame(7, 11, 3, 0, 2);
    // Table full: nine open frames.
    for (int f = 0; f < 9; f++) push(good_frag(100, 500 + f, 0, 0, 0, 0, 2, 5));
    it = '{default: '0}; it.fn = 1; clock_ms += 48'hFFFF_FFFF; it.now = clock_ms; push(it);
    // Silence and size limit settings.
    push_cfg(CFG_SILENCE_MASK, 32'h8000);
    it = good_frag(3, 3, 0, 0, 16'h8000, 0, 1, 0); it.pay = 0; push(it);
    it.pay = 1; push(it);
    it.pay = 0; it.cnt = 2; push(it);
    push_cfg(CFG_MAX_BYTES, 32'd3000);
    push(good_frag(4, 4, 0, 0, 0, 2, 3, FRAGMENT_BYTES));
    push_cfg(CFG_MAX_BYTES, 32'd0);
    push(good_frag(4, 5, 0, 0, 0, 0, 1, 1));
    push_cfg(CFG_MAX_BYTES, 32'd16384);
    push_cfg(CFG_SILENCE_MASK, 32'hFFFF);
    push_cfg(CFG_SILENCE_MASK, 32'h0);
    // Random part over several timeout and silence settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: push_cfg(CFG_TIMEOUT, 32'd0);
        1: push_cfg(CFG_TIMEOUT, 32'd40);
        2: push_cfg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        3: push_cfg(CFG_SILENCE_MASK, 32'h0001);
        default: push_cfg(CFG_TIMEOUT, 32'd1000);
      endcase
      while (pending_items.size() < 105 * (ph + 1) + 40) begin
        if ($urandom_range(0, 3) != 0)
          push_frame($urandom_range(0, 2), $urandom_range(1, 20), $urandom_range(1, 6),
                     $urandom_range(0, 1), $urandom_range(0, 8));
        else begin
          if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 2000);
          it = noise_item();
          if ($urandom_range(0, 30) == 0) it.now = clock_ms - $urandom_range(1, 50);
          push(it);
        end
      end
    end
    // Time at its top value, a sweep with a zero timeout, then time going back.
    it = '{default: '0}; it.fn = 1; it.now = 48'hFFFF_FFFF_FFFF; push(it);
    push_cfg(CFG_TIMEOUT, 32'd0);
    it.now = 48'hFFFF_FFFF_FFFF; push(it);
    clock_ms = 48'hFFFF_FFFF_FFFF;
    it = noise_item(); it.now = 0; push(it);
    stim_done = 1;
  end

  // Driver: applies items, config writes and drain pauses.
  int gap = 0;
  bit wait_start = 0;
  always @(posedge clk) begin
    frag_item_t it;
    frag_result_t r;
    if (rst) begin
      start <= 0; cfg_write <= 0;
    end else if (wait_start && !busy && start) begin
      // Item accepted at this edge; start drops and a random gap may follow.
      wait_start = 0;
      start <= 0;
      gap = calm ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0);
    end else if (start) begin
    end else if (gap > 0) begin
      gap--;
      cfg_write <= 0;
    end else if (pending_items.size() > 0) begin
      it = pending_items[0];
      if (pending_items.size() < 60) calm = 1;
      if (it.is_cfg) begin
        void'(pending_items.pop_front());
        cfg_write <= 1; cfg_index <= it.reg_sel; cfg_data <= it.reg_val;
        case (it.reg_sel)
          CFG_SILENCE_MASK: m_silence = it.reg_val[15:0];
          CFG_TIMEOUT:      m_timeout = it.reg_val;
          default:          m_max_bytes = it.reg_val[14:0];
        endcase
      end else begin
        cfg_write <= 0;
        if (it.is_drain) begin
          if (expected_results.size() == 0 && !busy) begin
            void'(pending_items.pop_front());
            gap = 12;
          end
        end else begin
          void'(pending_items.pop_front());
          track_fragment(it, r);
          expected_results.push_back(r);
          start <= 1; wait_start = 1;
          func <= it.fn; now_ms <= it.now; parse_ok <= it.pok; is_audio <= it.aud;
          strm_id <= it.sid; frm_id <= it.fid; seq_num <= it.seq;
          sample_stamp <= it.stamp; flags <= it.flg;
          frag_pos <= it.idx; frag_cnt <= it.cnt; payload_bytes <= it.pay;
        end
      end
    end else cfg_write <= 0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    frag_result_t e;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", 64'd1, 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (error_code !== e.err) report_mismatch("error_code", error_code, e.err);
        if (expired_count !== e.expired)
          report_mismatch("expired_count", expired_count, e.expired);
        if (frame_done !== e.done) report_mismatch("frame_done", frame_done, e.done);
        if (slot_index !== e.slot) report_mismatch("slot_index", slot_index, e.slot);
        if (write_offset !== e.offset)
          report_mismatch("write_offset", write_offset, e.offset);
        if (done_strm_id !== e.d_sid)
          report_mismatch("done_strm_id", done_strm_id, e.d_sid);
        if (done_first_sequence !== e.d_seq)
          report_mismatch("done_first_sequence", done_first_sequence, e.d_seq);
        if (done_timestamp !== e.d_stamp)
          report_mismatch("done_timestamp", done_timestamp, e.d_stamp);
        if (done_frame_id !== e.d_fid)
          report_mismatch("done_frame_id", done_frame_id, e.d_fid);
        if (done_flags !== e.d_flg) report_mismatch("done_flags", done_flags, e.d_flg);
        if (frame_bytes !== e.bytes) report_mismatch("frame_bytes", frame_bytes, e.bytes);
        if (in_flight_count !== e.inflight)
          report_mismatch("in_flight_count", in_flight_count, e.inflight);
      end
    end
  end

  // Reset, then wait for the queues to empty.
  initial begin
    m_silence = 0; m_timeout = 1000; m_max_bytes = 16384;
    clear_table();
    m_time_seen = 0; m_last_time = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    wait (stim_done && pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
